// File: hdl/mtta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtta_pkg
// Shared types and constants for the macro-tiled texture address pipeline:
// register indexes, element size codes, bank swap order and divider state.
// ----------------------------------------------------------------------------
package mtta_pkg;

  localparam logic [2:0] REG_BITS_PER_ELEMENT = 3'd0;
  localparam logic [2:0] REG_DEPTH_LAYOUT     = 3'd1;
  localparam logic [2:0] REG_SURFACE_PITCH    = 3'd2;
  localparam logic [2:0] REG_SURFACE_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_TILE_ASPECT      = 3'd4;
  localparam logic [2:0] REG_SURFACE_SWIZZLE  = 3'd5;
  localparam logic [2:0] REG_TILE_ROTATION    = 3'd6;
  localparam logic [2:0] REG_BANK_SWAP        = 3'd7;

  localparam int ELEM_CODES = 6;
  localparam int ASPECT_CODES = 3;

  typedef enum logic [2:0] {
    ELEM_8,
    ELEM_16,
    ELEM_32,
    ELEM_64,
    ELEM_96,
    ELEM_128
  } elem_code_t;

  localparam int SWAP_W = 14;
  localparam int DIVIDEND_W = 16;
  localparam int DIV_STEPS = 4;

  localparam logic [2:0] SWAP_ORDER [8] = '{
    3'd0, 3'd1, 3'd3, 3'd2, 3'd6, 3'd7, 3'd5, 3'd4
  };

  typedef struct packed {
    logic [SWAP_W-1:0]     rem;
    logic [DIVIDEND_W-1:0] dsr;
    logic [DIVIDEND_W-1:0] quo;
  } div_state_t;

  function automatic int elem_size(input int code);
    int r;
    case (code)
      int'(ELEM_8):   r = 8;
      int'(ELEM_16):  r = 16;
      int'(ELEM_64):  r = 64;
      int'(ELEM_96):  r = 96;
      int'(ELEM_128): r = 128;
      default: r = 32;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/macro_tiled_texture_address_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macro_tiled_texture_address_top
// Byte offset of a texel in a thin 2D macro-tiled surface: micro tile index,
// macro tile and slice offset, bank/pipe rotation and optional bank swap.
//
//   channel | direction | signals
//   --------+-----------+--------------------------------------------------
//   in      | sink      | in_valid in_ready coord_x coord_y slice_index
//           |           | depth_tile_base depth_comp_bits
//   out     | source    | out_valid out_ready byte_offset
//   cfg     | sink      | cfg_valid cfg_ready cfg_index cfg_data
//
// one transaction per cycle while out_ready does not stall the output register
// stages are sized by the 16-step bank swap divider (4 steps per stage) and the
// chained slice offset multipliers (pitch*height, *element bytes, *slice)
// reset clears valid bits and loads register defaults; no clearing pass
// each stage has its own ready, so bubbles close up and a stall drops nothing
// bank and pipe counts are powers of two
// ----------------------------------------------------------------------------
module macro_tiled_texture_address_top #(
  parameter int BANK_COUNT = 4,
  parameter int PIPE_COUNT = 2,
  parameter int GROUP_BITS = 8,
  parameter int SWAP_BYTES = 256,
  parameter int ROW_BYTES  = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] coord_x,
  input  logic [13:0] coord_y,
  input  logic [7:0]  slice_index,
  input  logic [15:0] depth_tile_base,
  input  logic [7:0]  depth_comp_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] byte_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int BB = $clog2(BANK_COUNT);
  localparam int PB = $clog2(PIPE_COUNT);
  localparam int PBW = (PB > 0) ? PB : 1;
  localparam int SW = mtta_pkg::SWAP_W;
  localparam int DW = mtta_pkg::DIVIDEND_W;
  localparam logic [31:0] GMASK = 32'((64'd1 << GROUP_BITS) - 64'd1);

  // configuration registers
  logic [7:0]  bits_per_element;
  logic        depth_layout;
  logic [14:0] surface_pitch;
  logic [14:0] surface_height;
  logic [2:0]  tile_aspect;
  logic [11:0] surface_swizzle;
  logic [3:0]  tile_rotation;
  logic        bank_swap_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_element <= 8'd32;
      depth_layout     <= 1'b0;
      surface_pitch    <= 15'd256;
      surface_height   <= 15'd256;
      tile_aspect      <= 3'd1;
      surface_swizzle  <= 12'd0;
      tile_rotation    <= 4'd0;
      bank_swap_en     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtta_pkg::REG_BITS_PER_ELEMENT: bits_per_element <= cfg_data[7:0];
        mtta_pkg::REG_DEPTH_LAYOUT:     depth_layout     <= cfg_data[0];
        mtta_pkg::REG_SURFACE_PITCH:    surface_pitch    <= cfg_data;
        mtta_pkg::REG_SURFACE_HEIGHT:   surface_height   <= cfg_data;
        mtta_pkg::REG_TILE_ASPECT:      tile_aspect      <= cfg_data[2:0];
        mtta_pkg::REG_SURFACE_SWIZZLE:  surface_swizzle  <= cfg_data[11:0];
        mtta_pkg::REG_TILE_ROTATION:    tile_rotation    <= cfg_data[3:0];
        mtta_pkg::REG_BANK_SWAP:        bank_swap_en     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // configuration decode
  mtta_pkg::elem_code_t ecode;
  logic [7:0]  ev;
  logic [4:0]  e8;
  logic [1:0]  la;
  logic [15:0] pitch2;

  always_comb begin
    case (bits_per_element)
      8'd8:    ecode = mtta_pkg::ELEM_8;
      8'd16:   ecode = mtta_pkg::ELEM_16;
      8'd64:   ecode = mtta_pkg::ELEM_64;
      8'd96:   ecode = mtta_pkg::ELEM_96;
      8'd128:  ecode = mtta_pkg::ELEM_128;
      default: ecode = mtta_pkg::ELEM_32;
    endcase
    case (tile_aspect)
      3'd2:    la = 2'd1;
      3'd4:    la = 2'd2;
      default: la = 2'd0;
    endcase
    ev = 8'(mtta_pkg::elem_size(int'(ecode)));
    e8 = ev[7:3];
    pitch2 = {surface_pitch, 1'b0};
  end

  // bank swap width before pitch halving, per element size and aspect
  logic [SW-1:0] w0_tab [mtta_pkg::ELEM_CODES][mtta_pkg::ASPECT_CODES];

  for (genvar ei = 0; ei < mtta_pkg::ELEM_CODES; ei++) begin : g_we
    for (genvar ai = 0; ai < mtta_pkg::ASPECT_CODES; ai++) begin : g_wa
      localparam int E = mtta_pkg::elem_size(ei);
      localparam int A = 1 << ai;
      localparam int TILES0 = (SWAP_BYTES / 2) / E;
      localparam int TILES = (TILES0 < 1) ? 1 : TILES0;
      localparam int WIDE = TILES * 8 * BANK_COUNT;
      localparam int WMAX = (PIPE_COUNT * BANK_COUNT * ROW_BYTES) / (A * PIPE_COUNT * E);
      localparam int WMIN = ((1 << GROUP_BITS) * 8 * BANK_COUNT) / (8 * E);
      localparam int WHI = (WMIN > WIDE) ? WMIN : WIDE;
      localparam int WCL = (WMAX < WHI) ? WMAX : WHI;
      localparam int W0 = (WCL == 0) ? 1 : WCL;
      assign w0_tab[ei][ai] = SW'(W0);
    end
  end

  logic [SW-1:0] w0;
  logic [SW-1:0] wk;
  logic [3:0]    kcnt;
  logic [SW-1:0] w_eff;

  always_comb begin
    w0 = w0_tab[ecode][la];
    kcnt = 4'd0;
    for (int k = 0; k < SW; k++) begin
      wk = w0 >> k;
      if (wk > SW'(1) && {2'b00, wk} >= pitch2) begin
        kcnt = kcnt + 4'd1;
      end
    end
    w_eff = w0 >> kcnt;
  end

  function automatic logic [5:0] micro_index(input logic depth,
                                             input mtta_pkg::elem_code_t ec,
                                             input logic [2:0] x,
                                             input logic [2:0] y);
    logic [5:0] b;
    if (depth) begin
      b = {y[2], x[2], y[1], x[1], y[0], x[0]};
    end else begin
      case (ec)
        mtta_pkg::ELEM_8:   b = {y[2], y[0], y[1], x[2], x[1], x[0]};
        mtta_pkg::ELEM_16:  b = {y[2], y[1], y[0], x[2], x[1], x[0]};
        mtta_pkg::ELEM_64:  b = {y[2], y[1], x[2], x[1], y[0], x[0]};
        mtta_pkg::ELEM_128: b = {y[2], y[1], x[2], x[1], x[0], y[0]};
        default:            b = {y[2], y[1], x[2], y[0], x[1], x[0]};
      endcase
    end
    return b;
  endfunction

  function automatic mtta_pkg::div_state_t div_run(input mtta_pkg::div_state_t st,
                                                   input logic [SW-1:0] dvs);
    mtta_pkg::div_state_t r;
    logic [SW:0] trial;
    r = st;
    for (int i = 0; i < mtta_pkg::DIV_STEPS; i++) begin
      trial = {r.rem, r.dsr[DW-1]};
      r.dsr = r.dsr << 1;
      if (trial >= {1'b0, dvs}) begin
        r.rem = SW'(trial - {1'b0, dvs});
        r.quo = {r.quo[DW-2:0], 1'b1};
      end else begin
        r.rem = trial[SW-1:0];
        r.quo = {r.quo[DW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // stage handshake
  logic [4:0] vld;
  logic [4:0] rdy;

  always_comb begin
    rdy[4] = !vld[4] || out_ready;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int i = 1; i < 5; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 1: micro index, element offset, bank/pipe, macro tile position
  logic [5:0]    pix;
  logic [16:0]   eo_full;
  logic [13:0]   mtx_n;
  logic [1:0]    bank2;
  logic          pipe1;
  logic [12:0]   bpx;
  mtta_pkg::div_state_t div_n;

  always_comb begin
    pix = micro_index(depth_layout, ecode, coord_x[2:0], coord_y[2:0]);
    if (depth_layout && depth_comp_bits != 8'd0 && depth_comp_bits != ev) begin
      eo_full = 17'(depth_tile_base) + 17'(depth_comp_bits) * 17'(pix);
    end else begin
      eo_full = 17'(ev) * 17'(pix);
    end
    mtx_n = coord_x >> (BB + 3 - int'(la));
    bank2 = {coord_y[3+PB] ^ coord_x[4], coord_y[4+PB] ^ coord_x[3]};
    pipe1 = coord_y[3] ^ coord_x[3];
    bpx = ((13'(bank2) << PB) | 13'(pipe1))
        ^ (13'(surface_swizzle[8]) + 13'(PIPE_COUNT) * 13'(surface_swizzle[11:9])
           + 13'(slice_index) * 13'(tile_rotation));
    div_n.rem = '0;
    div_n.dsr = DW'(DW'(mtx_n) << (BB + 3 - int'(la)));
    div_n.quo = '0;
  end

  logic [13:0]   s1_eo;
  logic [29:0]   s1_ph;
  logic [13:0]   s1_mtx;
  logic [13:0]   s1_mty;
  logic [7:0]    s1_s;
  logic [BB-1:0] s1_bank;
  logic [PBW-1:0] s1_pipe;
  logic [SW-1:0] s1_w;
  mtta_pkg::div_state_t s1_div;

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      s1_eo   <= eo_full[16:3];
      s1_ph   <= 30'(surface_pitch) * 30'(surface_height);
      s1_mtx  <= mtx_n;
      s1_mty  <= coord_y >> (PB + 3 + int'(la));
      s1_s    <= slice_index;
      s1_bank <= BB'((bpx >> PB) & 13'(BANK_COUNT - 1));
      s1_pipe <= PBW'(bpx & 13'(PIPE_COUNT - 1));
      s1_w    <= w_eff;
      s1_div  <= div_n;
    end
  end

  // stage 2: macro tile index, bytes per slice
  logic [14:0] pdiv;
  assign pdiv = surface_pitch >> (BB + 3 - int'(la));

  logic [13:0]   s2_eo;
  logic [29:0]   s2_m1;
  logic [31:0]   s2_sp;
  logic [7:0]    s2_s;
  logic [BB-1:0] s2_bank;
  logic [PBW-1:0] s2_pipe;
  logic [SW-1:0] s2_w;
  mtta_pkg::div_state_t s2_div;

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      s2_eo   <= s1_eo;
      s2_m1   <= 30'(pdiv) * 30'(s1_mty) + 30'(s1_mtx);
      s2_sp   <= 32'(s1_ph) * 32'(e8);
      s2_s    <= s1_s;
      s2_bank <= s1_bank;
      s2_pipe <= s1_pipe;
      s2_w    <= s1_w;
      s2_div  <= div_run(s1_div, s1_w);
    end
  end

  // stage 3: macro tile and slice byte offsets
  logic [13:0]   s3_eo;
  logic [31:0]   s3_mo;
  logic [31:0]   s3_so;
  logic [BB-1:0] s3_bank;
  logic [PBW-1:0] s3_pipe;
  logic [SW-1:0] s3_w;
  mtta_pkg::div_state_t s3_div;

  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      s3_eo   <= s2_eo;
      s3_mo   <= 32'((32'(s2_m1) * 32'(e8)) << (6 + BB + PB));
      s3_so   <= s2_sp * 32'(s2_s);
      s3_bank <= s2_bank;
      s3_pipe <= s2_pipe;
      s3_w    <= s2_w;
      s3_div  <= div_run(s2_div, s2_w);
    end
  end

  // stage 4: element offset plus macro tile and slice offsets
  logic [31:0] mt_sum;
  assign mt_sum = s3_mo + s3_so;

  logic [31:0]   s4_total;
  logic [BB-1:0] s4_bank;
  logic [PBW-1:0] s4_pipe;
  logic [SW-1:0] s4_w;
  mtta_pkg::div_state_t s4_div;

  always_ff @(posedge clk) begin
    if (rdy[3] && vld[2]) begin
      s4_total <= 32'(s3_eo) + (mt_sum >> (BB + PB));
      s4_bank  <= s3_bank;
      s4_pipe  <= s3_pipe;
      s4_w     <= s3_w;
      s4_div   <= div_run(s3_div, s3_w);
    end
  end

  // stage 5: bank swap and bank/pipe interleave
  mtta_pkg::div_state_t div_f;
  logic [2:0]    swap_idx;
  logic [BB-1:0] bank_f;

  always_comb begin
    div_f = div_run(s4_div, s4_w);
    swap_idx = 3'(div_f.quo[BB-1:0]);
    if (bank_swap_en) begin
      bank_f = s4_bank ^ mtta_pkg::SWAP_ORDER[swap_idx][BB-1:0];
    end else begin
      bank_f = s4_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && vld[3]) begin
      byte_offset <= ((s4_total & ~GMASK) << (BB + PB)) | (s4_total & GMASK)
                   | (32'(bank_f) << (PB + GROUP_BITS)) | (32'(s4_pipe) << GROUP_BITS);
    end
  end

`ifndef SYNTHESIS
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (s2_div.rem < s2_w))
    else $error("swap divider remainder not below divisor");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && !rdy[1]) |=> (vld[0] && $stable(s1_eo) && $stable(s1_div)))
    else $error("stalled stage 1 transaction lost or changed");

  a_swap_width: assert property (@(posedge clk) disable iff (rst)
    (w_eff == SW'(1)) || ({2'b00, w_eff} < pitch2))
    else $error("bank swap width not reduced below twice the pitch");

  a_out_from_s4: assert property (@(posedge clk) disable iff (rst)
    $rose(vld[4]) |-> $past(vld[3]))
    else $error("output valid without a transaction in stage 4");
`endif

endmodule
